// File: src/brf_pkg.sv
// Shared types, codes and a decode function for the banked register file.
package brf_pkg;

  localparam int unsigned SLOT_COUNT = 31;
  localparam int unsigned SLOT_W     = 5;

  localparam logic [2:0] OP_READ       = 3'd0;
  localparam logic [2:0] OP_WRITE      = 3'd1;
  localparam logic [2:0] OP_READ_USER  = 3'd2;
  localparam logic [2:0] OP_WRITE_USER = 3'd3;
  localparam logic [2:0] OP_SET_MODE   = 3'd4;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  localparam logic [SLOT_W-1:0] BASE_SVC = 5'd16;
  localparam logic [SLOT_W-1:0] BASE_ABT = 5'd18;
  localparam logic [SLOT_W-1:0] BASE_UND = 5'd20;
  localparam logic [SLOT_W-1:0] BASE_IRQ = 5'd22;
  localparam logic [SLOT_W-1:0] BASE_FIQ = 5'd24;

  localparam logic [2:0] SPSR_SVC = 3'd0;
  localparam logic [2:0] SPSR_ABT = 3'd1;
  localparam logic [2:0] SPSR_UND = 3'd2;
  localparam logic [2:0] SPSR_IRQ = 3'd3;
  localparam logic [2:0] SPSR_FIQ = 3'd4;

  localparam logic [3:0] IDX_NONE = 4'd15;

  typedef struct packed {
    logic [2:0] spsr_index;
    logic       no_spsr;
    logic       defined;
  } mode_info_t;

  function automatic logic mode_defined(input logic [4:0] m);
    logic ok;
    ok = (m == MODE_USR) || (m == MODE_FIQ) || (m == MODE_IRQ) || (m == MODE_SVC) ||
         (m == MODE_ABT) || (m == MODE_UND) || (m == MODE_SYS);
    return ok;
  endfunction

endpackage

// File: src/banked_register_file_unit.sv
// Top level of the mode-banked register file.
//
// Input channel: operation, reg_index, write_data and new_mode move as one beat
// when in_valid is high and in_stall is low. Output channel: read_data,
// saved_status_index, no_saved_status and bad_mode move as one beat when
// out_valid is high and out_stall is low. Every input beat yields one output beat.
// An accepted beat sits in the input register, where the slot lookup, register
// write, mode update and read happen; its result is loaded into the output
// register once the output can advance (out_valid low or out_stall low), and is
// taken from there. One beat per cycle is sustained while out_stall is low.
// Reset clears all 31 physical registers to zero and sets the mode to user.
// While out_stall holds a waiting result, the input register still takes one
// beat; after that in_stall rises and both stages hold until the output drains.
module banked_register_file_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [4:0]  new_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic [2:0]  saved_status_index,
  output logic        no_saved_status,
  output logic        bad_mode
);

  logic        s1_valid;
  logic [2:0]  s1_op;
  logic [3:0]  s1_idx;
  logic [31:0] s1_data;
  logic [4:0]  s1_mode_req;
  logic [4:0]  cur_mode;
  logic [4:0]  cur_mode_next;

  logic                        advance;
  logic                        fire;
  logic                        idx_ok;
  logic                        is_user;
  logic                        is_read;
  logic                        is_write;
  logic                        set_ok;
  logic                        set_bad;
  logic [brf_pkg::SLOT_W-1:0]  slot;
  logic [31:0]                 rf_rdata;
  brf_pkg::mode_info_t         info;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign fire     = s1_valid && advance;

  assign idx_ok   = (s1_idx != brf_pkg::IDX_NONE);
  assign is_user  = (s1_op == brf_pkg::OP_READ_USER) || (s1_op == brf_pkg::OP_WRITE_USER);
  assign is_read  = (s1_op == brf_pkg::OP_READ) || (s1_op == brf_pkg::OP_READ_USER);
  assign is_write = (s1_op == brf_pkg::OP_WRITE) || (s1_op == brf_pkg::OP_WRITE_USER);
  assign set_ok   = (s1_op == brf_pkg::OP_SET_MODE) && brf_pkg::mode_defined(s1_mode_req);
  assign set_bad  = (s1_op == brf_pkg::OP_SET_MODE) && !brf_pkg::mode_defined(s1_mode_req);

  assign cur_mode_next = set_ok ? s1_mode_req : cur_mode;

  brf_map u_map (
    .cur_mode    (cur_mode),
    .status_mode (cur_mode_next),
    .reg_idx     (s1_idx),
    .user_bank   (is_user),
    .slot        (slot),
    .info        (info)
  );

  brf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fire && idx_ok && is_write),
    .wr_slot (slot),
    .wr_data (s1_data),
    .rd_slot (slot),
    .rd_data (rf_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cur_mode <= brf_pkg::MODE_USR;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        cur_mode <= cur_mode_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op       <= operation;
      s1_idx      <= reg_index;
      s1_data     <= write_data;
      s1_mode_req <= new_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data          <= (idx_ok && is_read) ? rf_rdata : '0;
      saved_status_index <= info.spsr_index;
      no_saved_status    <= info.no_spsr;
      bad_mode           <= set_bad || !info.defined;
    end
  end

endmodule

// File: src/brf_map.sv
// Mode decode: logical index to physical slot, and SPSR status of a mode.
module brf_map (
  input  logic [4:0]                  cur_mode,
  input  logic [4:0]                  status_mode,
  input  logic [3:0]                  reg_idx,
  input  logic                        user_bank,
  output logic [brf_pkg::SLOT_W-1:0]  slot,
  output brf_pkg::mode_info_t         info
);

  logic [brf_pkg::SLOT_W-1:0] idx_w;
  logic [4:0]                 map_mode;

  assign idx_w    = {1'b0, reg_idx};
  assign map_mode = user_bank ? brf_pkg::MODE_USR : cur_mode;

  always_comb begin
    slot = idx_w;
    unique case (map_mode)
      brf_pkg::MODE_SVC: if (reg_idx >= 4'd13) slot = brf_pkg::BASE_SVC + (idx_w - 5'd13);
      brf_pkg::MODE_ABT: if (reg_idx >= 4'd13) slot = brf_pkg::BASE_ABT + (idx_w - 5'd13);
      brf_pkg::MODE_UND: if (reg_idx >= 4'd13) slot = brf_pkg::BASE_UND + (idx_w - 5'd13);
      brf_pkg::MODE_IRQ: if (reg_idx >= 4'd13) slot = brf_pkg::BASE_IRQ + (idx_w - 5'd13);
      brf_pkg::MODE_FIQ: if (reg_idx >= 4'd8)  slot = brf_pkg::BASE_FIQ + (idx_w - 5'd8);
      default:           slot = idx_w;
    endcase
  end

  always_comb begin
    info.defined    = brf_pkg::mode_defined(status_mode);
    info.no_spsr    = 1'b0;
    info.spsr_index = brf_pkg::SPSR_SVC;
    unique case (status_mode)
      brf_pkg::MODE_SVC: info.spsr_index = brf_pkg::SPSR_SVC;
      brf_pkg::MODE_ABT: info.spsr_index = brf_pkg::SPSR_ABT;
      brf_pkg::MODE_UND: info.spsr_index = brf_pkg::SPSR_UND;
      brf_pkg::MODE_IRQ: info.spsr_index = brf_pkg::SPSR_IRQ;
      brf_pkg::MODE_FIQ: info.spsr_index = brf_pkg::SPSR_FIQ;
      default:           info.no_spsr    = 1'b1;
    endcase
  end

endmodule

// File: src/brf_regs.sv
// Physical register storage: 31 slots, one write port and one read port.
module brf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [brf_pkg::SLOT_W-1:0]  wr_slot,
  input  logic [31:0]                 wr_data,
  input  logic [brf_pkg::SLOT_W-1:0]  rd_slot,
  output logic [31:0]                 rd_data
);

  logic [31:0] regs [brf_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < brf_pkg::SLOT_COUNT; i++) begin
        regs[i] <= '0;
      end
    end else if (wr_en && (wr_slot < brf_pkg::SLOT_W'(brf_pkg::SLOT_COUNT))) begin
      regs[wr_slot] <= wr_data;
    end
  end

  assign rd_data = (rd_slot < brf_pkg::SLOT_W'(brf_pkg::SLOT_COUNT)) ? regs[rd_slot] : '0;

endmodule

// File: sim/brf_checker.sv
// Checker for the banked register file: watches both channels, predicts and compares each beat.
module brf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic [4:0]  new_mode,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] read_data,
  input  logic [2:0]  saved_status_index,
  input  logic        no_saved_status,
  input  logic        bad_mode,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  spsr;
    logic        no_spsr;
    logic        bad;
  } beat_t;

  logic [31:0] shadow_regs [brf_pkg::SLOT_COUNT];
  logic [4:0]  shadow_mode;
  beat_t       expected_beats [$];
  int unsigned errs = 0;

  function automatic logic known_mode(input logic [4:0] m);
    case (m)
      brf_pkg::MODE_USR, brf_pkg::MODE_FIQ, brf_pkg::MODE_IRQ, brf_pkg::MODE_SVC,
      brf_pkg::MODE_ABT, brf_pkg::MODE_UND, brf_pkg::MODE_SYS: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [brf_pkg::SLOT_W-1:0] bank_slot(input logic [4:0] m,
                                                            input logic [3:0] idx);
    logic [brf_pkg::SLOT_W-1:0] slot;
    slot = {1'b0, idx};
    case (m)
      brf_pkg::MODE_FIQ: if (idx >= 4'd8) slot = brf_pkg::BASE_FIQ + {1'b0, idx} - 5'd8;
      brf_pkg::MODE_SVC: if (idx >= 4'd13) slot = brf_pkg::BASE_SVC + {1'b0, idx} - 5'd13;
      brf_pkg::MODE_ABT: if (idx >= 4'd13) slot = brf_pkg::BASE_ABT + {1'b0, idx} - 5'd13;
      brf_pkg::MODE_UND: if (idx >= 4'd13) slot = brf_pkg::BASE_UND + {1'b0, idx} - 5'd13;
      brf_pkg::MODE_IRQ: if (idx >= 4'd13) slot = brf_pkg::BASE_IRQ + {1'b0, idx} - 5'd13;
      default: ;
    endcase
    return slot;
  endfunction

  task automatic predict_access(input logic [2:0] op, input logic [3:0] idx,
                                input logic [31:0] data, input logic [4:0] nm);
    beat_t b;
    b = '0;
    case (op)
      brf_pkg::OP_READ: begin
        if (idx != brf_pkg::IDX_NONE) b.read_data = shadow_regs[bank_slot(shadow_mode, idx)];
      end
      brf_pkg::OP_WRITE: begin
        if (idx != brf_pkg::IDX_NONE) shadow_regs[bank_slot(shadow_mode, idx)] = data;
      end
      brf_pkg::OP_READ_USER: begin
        if (idx != brf_pkg::IDX_NONE) b.read_data = shadow_regs[idx];
      end
      brf_pkg::OP_WRITE_USER: begin
        if (idx != brf_pkg::IDX_NONE) shadow_regs[idx] = data;
      end
      brf_pkg::OP_SET_MODE: begin
        if (known_mode(nm)) shadow_mode = nm;
        else b.bad = 1'b1;
      end
      default: ;
    endcase
    if (!known_mode(shadow_mode)) b.bad = 1'b1;
    case (shadow_mode)
      brf_pkg::MODE_SVC: b.spsr = brf_pkg::SPSR_SVC;
      brf_pkg::MODE_ABT: b.spsr = brf_pkg::SPSR_ABT;
      brf_pkg::MODE_UND: b.spsr = brf_pkg::SPSR_UND;
      brf_pkg::MODE_IRQ: b.spsr = brf_pkg::SPSR_IRQ;
      brf_pkg::MODE_FIQ: b.spsr = brf_pkg::SPSR_FIQ;
      default: begin
        b.spsr    = brf_pkg::SPSR_SVC;
        b.no_spsr = 1'b1;
      end
    endcase
    expected_beats.push_back(b);
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst) begin
      for (int i = 0; i < brf_pkg::SLOT_COUNT; i++) shadow_regs[i] = '0;
      shadow_mode = brf_pkg::MODE_USR;
      expected_beats.delete();
    end else begin
      if (in_valid && !in_stall) predict_access(operation, reg_index, write_data, new_mode);
      if (out_valid && !out_stall) begin
        got = '{read_data, saved_status_index, no_saved_status, bad_mode};
        if (expected_beats.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("brf_checker: unexpected beat rd=%h spsr=%0d none=%b bad=%b",
                     got.read_data, got.spsr, got.no_spsr, got.bad);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10)
              $display("brf_checker: exp rd=%h s=%0d n=%b b=%b got rd=%h s=%0d n=%b b=%b",
                       want.read_data, want.spsr, want.no_spsr, want.bad,
                       got.read_data, got.spsr, got.no_spsr, got.bad);
          end
        end
      end
    end
    mismatches  <= errs;
    outstanding <= expected_beats.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the banked register file: clock, reset, stimulus and verdict.
module tb_top;

  localparam int unsigned RANDOM_BEATS   = 900;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  operation;
  logic [3:0]  reg_index;
  logic [31:0] write_data;
  logic [4:0]  new_mode;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic [2:0]  saved_status_index;
  logic        no_saved_status;
  logic        bad_mode;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;

  logic [4:0] mode_list [7] = '{brf_pkg::MODE_USR, brf_pkg::MODE_FIQ, brf_pkg::MODE_IRQ,
                                brf_pkg::MODE_SVC, brf_pkg::MODE_ABT, brf_pkg::MODE_UND,
                                brf_pkg::MODE_SYS};

  always #6 clk = ~clk;

  banked_register_file_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .reg_index(reg_index),
    .write_data(write_data), .new_mode(new_mode),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .saved_status_index(saved_status_index),
    .no_saved_status(no_saved_status), .bad_mode(bad_mode)
  );

  brf_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .reg_index(reg_index),
    .write_data(write_data), .new_mode(new_mode),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .saved_status_index(saved_status_index),
    .no_saved_status(no_saved_status), .bad_mode(bad_mode),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input logic [2:0] op, input logic [3:0] idx,
                           input logic [31:0] data, input logic [4:0] nm);
    int unsigned gap;
    operation  <= op;
    reg_index  <= idx;
    write_data <= data;
    new_mode   <= nm;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_beat();
    int unsigned r;
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [31:0] data;
    logic [4:0]  nm;
    r = $urandom_range(0, 99);
    if (r < 30) op = brf_pkg::OP_READ;
    else if (r < 55) op = brf_pkg::OP_WRITE;
    else if (r < 65) op = brf_pkg::OP_READ_USER;
    else if (r < 75) op = brf_pkg::OP_WRITE_USER;
    else if (r < 92) op = brf_pkg::OP_SET_MODE;
    else op = 3'($urandom_range(5, 7));
    idx = ($urandom_range(0, 99) < 65) ? 4'($urandom_range(8, 14)) : 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 5) data = '0;
    else if (r < 10) data = '1;
    else data = $urandom();
    nm = ($urandom_range(0, 99) < 80) ? mode_list[$urandom_range(0, 6)]
                                      : 5'($urandom_range(0, 31));
    send_beat(op, idx, data, nm);
  endtask

  initial begin
    out_stall = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < 35);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = '0;
    reg_index  = '0;
    write_data = '0;
    new_mode   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_beat(brf_pkg::OP_READ, 4'd0, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_WRITE, 4'd0, 32'hFFFF_FFFF, 5'h1F);
    send_beat(brf_pkg::OP_WRITE, 4'd14, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_WRITE_USER, 4'd13, 32'hA5A5_A5A5, 5'h0);
    send_beat(brf_pkg::OP_READ, 4'd0, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_READ, 4'd13, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_WRITE, brf_pkg::IDX_NONE, 32'h1234_5678, 5'h0);
    send_beat(brf_pkg::OP_READ, brf_pkg::IDX_NONE, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_READ_USER, brf_pkg::IDX_NONE, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, brf_pkg::MODE_FIQ);
    send_beat(brf_pkg::OP_WRITE, 4'd8, 32'hDEAD_BEEF, 5'h0);
    send_beat(brf_pkg::OP_WRITE, 4'd14, 32'hFFFF_FFFF, 5'h0);
    send_beat(brf_pkg::OP_READ, 4'd8, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_READ_USER, 4'd8, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, brf_pkg::MODE_SVC);
    send_beat(brf_pkg::OP_WRITE, 4'd13, 32'h1111_2222, 5'h0);
    send_beat(brf_pkg::OP_READ, 4'd14, 32'h0, 5'h0);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, brf_pkg::MODE_IRQ);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, brf_pkg::MODE_ABT);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, brf_pkg::MODE_UND);
    send_beat(brf_pkg::OP_WRITE, 4'd14, 32'h5555_AAAA, 5'h0);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, 5'h00);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, 5'h1E);
    send_beat(brf_pkg::OP_SET_MODE, 4'd0, 32'h0, brf_pkg::MODE_SYS);
    send_beat(brf_pkg::OP_READ, 4'd13, 32'h0, 5'h0);
    send_beat(3'd5, brf_pkg::IDX_NONE, 32'hFFFF_FFFF, 5'h1F);
    send_beat(3'd7, 4'd14, 32'h0, 5'h0);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 600) calm = 1'b1;
      if (n == 700) calm = 1'b0;
      send_random_beat();
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
